// ===== rtl/mtg_pkg.sv =====
// Shared types and constants for the Mersenne Twister generator.
package mtg_pkg;

	localparam int unsigned TW_N = 624;
	localparam logic [9:0] TW_LAST = 10'd623;
	localparam logic [10:0] TW_M = 11'd397;
	localparam logic [9:0] TW_NOT_SEEDED = 10'd625;
	localparam logic [31:0] TW_MATRIX = 32'h9908b0df;
	localparam logic [31:0] TW_UPPER = 32'h80000000;
	localparam logic [31:0] MUL_SEED = 32'd1812433253;
	localparam logic [31:0] MUL_MIX1 = 32'd1664525;
	localparam logic [31:0] MUL_MIX2 = 32'd1566083941;
	localparam logic [31:0] SEED_KEY = 32'd19650218;
	localparam logic [31:0] SEED_DEFAULT = 32'd5489;
	localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C = 32'hefc60000;

	localparam logic [1:0] CMD_GENERATE = 2'd0;
	localparam logic [1:0] CMD_SEED = 2'd1;
	localparam logic [1:0] CMD_KEY = 2'd2;

	typedef enum logic [1:0] {
		OP_GEN,
		OP_SEED,
		OP_KEY
	} op_t;

	typedef struct packed {
		op_t op;
		logic [31:0] data;
		logic last;
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_WR,
		ST_GEN_RA,
		ST_GEN_RB,
		ST_GEN_RC,
		ST_GEN_WR,
		ST_MIX_RD,
		ST_MIX_WR,
		ST_FINAL
	} state_t;

endpackage

// ===== rtl/mtg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/mtg_front.sv =====
// Request intake: classifies commands and queues them in a two-entry buffer.
module mtg_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [31:0] data,
	input logic last,
	output logic req_valid,
	input logic req_ready,
	output mtg_pkg::req_t req
);
	import mtg_pkg::*;

	req_t buf_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;
	logic known;
	req_t incoming;

	always_comb begin
		known = 1'b1;
		incoming.data = data;
		incoming.last = last;
		case (cmd)
			CMD_GENERATE: incoming.op = OP_GEN;
			CMD_SEED: incoming.op = OP_SEED;
			CMD_KEY: incoming.op = OP_KEY;
			default: begin
				incoming.op = OP_GEN;
				known = 1'b0;
			end
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	// drop unused command codes at the door
	assign push = in_valid && in_ready && known;
	assign req_valid = (count_q != 2'd0);
	assign pop = req_valid && req_ready;
	assign req = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("request queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) count_q[0] == (wr_ptr_q ^ rd_ptr_q))
		else $error("request queue pointers out of step");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && count_q == 2'd0))
		else $error("request queue underflow");
endmodule

// ===== rtl/mtg_back.sv =====
// Command engine: seeding, key mixing and one-word twist with tempering.
module mtg_back #(
	parameter int KEY_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input mtg_pkg::req_t req,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] value
);
	import mtg_pkg::*;

	localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KCW = $clog2(KEY_DEPTH + 1);
	localparam int CW = (KCW > 10) ? KCW : 10;

	state_t state_q, state_d;
	op_t op_q;
	logic [9:0] widx_q, i_q;
	logic [31:0] prev_q, mul_q, a_q, b_q, value_q;
	logic [KAW-1:0] j_q;
	logic [KCW-1:0] len_q, kcnt_q;
	logic [CW-1:0] k_q;
	logic pass_q, out_valid_q;

	logic tw_we, key_we;
	logic [9:0] tw_waddr, tw_raddr;
	logic [31:0] tw_wdata, tw_rdata, key_rdata, seed_val, mul_c, mix_x;
	logic [31:0] seed_new, mix_new, gen_w, y;
	logic [9:0] i_inc, widx_inc, idx_p1, idx_pm;
	logic [10:0] pm_sum;
	logic [KCW-1:0] j_ext, len_acc;
	logic [CW-1:0] k_init;
	logic seed_go, unseeded, key_full, stall;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] t;
		t = x ^ (x >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

	mtg_ram #(.WIDTH(32), .DEPTH(TW_N)) u_tw_ram (
		.clk(clk), .we(tw_we), .waddr(tw_waddr), .wdata(tw_wdata),
		.raddr(tw_raddr), .rdata(tw_rdata)
	);

	mtg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(kcnt_q[KAW-1:0]), .wdata(req.data),
		.raddr(j_q), .rdata(key_rdata)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign unseeded = (widx_q >= 10'(TW_N));
	assign key_full = (kcnt_q == KCW'(KEY_DEPTH));
	assign len_acc = key_full ? kcnt_q : kcnt_q + KCW'(1);
	assign k_init = (CW'(len_acc) < CW'(TW_N)) ? CW'(TW_N) : CW'(len_acc);
	assign stall = out_valid_q && !out_ready;

	always_comb begin
		seed_go = 1'b0;
		seed_val = SEED_DEFAULT;
		if (req_valid) begin
			case (req.op)
				OP_GEN: seed_go = unseeded;
				OP_SEED: begin
					seed_go = 1'b1;
					seed_val = req.data;
				end
				OP_KEY: begin
					seed_go = req.last;
					seed_val = SEED_KEY;
				end
				default: seed_go = 1'b0;
			endcase
		end
	end

	assign mix_x = prev_q ^ (prev_q >> 30);
	assign mul_c = (state_q == ST_SEED_MUL) ? MUL_SEED : (pass_q ? MUL_MIX2 : MUL_MIX1);
	assign seed_new = mul_q + {22'd0, i_q};
	assign mix_new = pass_q ? ((tw_rdata ^ mul_q) - {22'd0, i_q})
		: ((tw_rdata ^ mul_q) + key_rdata + 32'(j_q));
	assign y = {a_q[31], b_q[30:0]};
	assign gen_w = tw_rdata ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
	assign i_inc = (i_q == TW_LAST) ? 10'd1 : i_q + 10'd1;
	assign widx_inc = (widx_q == TW_LAST) ? 10'd0 : widx_q + 10'd1;
	assign idx_p1 = widx_inc;
	assign pm_sum = {1'b0, widx_q} + TW_M;
	assign idx_pm = (pm_sum >= 11'(TW_N)) ? 10'(pm_sum - 11'(TW_N)) : pm_sum[9:0];
	assign j_ext = KCW'(j_q) + KCW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (seed_go) state_d = ST_SEED_MUL;
					else if (req.op == OP_GEN) state_d = ST_GEN_RA;
				end
			end
			ST_SEED_MUL: state_d = ST_SEED_WR;
			ST_SEED_WR: begin
				if (i_q != TW_LAST) state_d = ST_SEED_MUL;
				else if (op_q == OP_GEN) state_d = ST_GEN_RA;
				else if (op_q == OP_KEY) state_d = ST_MIX_RD;
				else state_d = ST_IDLE;
			end
			ST_GEN_RA: state_d = ST_GEN_RB;
			ST_GEN_RB: state_d = ST_GEN_RC;
			ST_GEN_RC: state_d = ST_GEN_WR;
			ST_GEN_WR: if (!stall) state_d = ST_IDLE;
			ST_MIX_RD: state_d = ST_MIX_WR;
			ST_MIX_WR: begin
				if (k_q == CW'(1) && pass_q) state_d = ST_FINAL;
				else state_d = ST_MIX_RD;
			end
			ST_FINAL: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		tw_we = 1'b0;
		tw_waddr = 10'd0;
		tw_wdata = seed_val;
		tw_raddr = i_q;
		key_we = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tw_we = seed_go;
				key_we = req_valid && (req.op == OP_KEY) && !key_full;
			end
			ST_SEED_WR: begin
				tw_we = 1'b1;
				tw_waddr = i_q;
				tw_wdata = seed_new;
			end
			ST_GEN_RA: tw_raddr = widx_q;
			ST_GEN_RB: tw_raddr = idx_p1;
			ST_GEN_RC: tw_raddr = idx_pm;
			ST_GEN_WR: begin
				tw_we = !stall;
				tw_waddr = widx_q;
				tw_wdata = gen_w;
				// hold the far word on the read port while the output stalls
				tw_raddr = idx_pm;
			end
			ST_MIX_WR: begin
				tw_we = 1'b1;
				tw_waddr = i_q;
				tw_wdata = mix_new;
			end
			ST_FINAL: begin
				tw_we = 1'b1;
				tw_wdata = TW_UPPER;
			end
			default: tw_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				prev_q <= seed_val;
				i_q <= 10'd1;
				op_q <= req.op;
				len_q <= len_acc;
				k_q <= k_init;
			end
			ST_SEED_MUL: mul_q <= mix_x * mul_c;
			ST_SEED_WR: begin
				i_q <= i_inc;
				// mixing starts from word zero, which still holds the seed
				prev_q <= (i_q == TW_LAST) ? SEED_KEY : seed_new;
				j_q <= '0;
			end
			ST_GEN_RB: a_q <= tw_rdata;
			ST_GEN_RC: b_q <= tw_rdata;
			ST_GEN_WR: if (!stall) value_q <= temper(gen_w);
			ST_MIX_RD: mul_q <= mix_x * mul_c;
			ST_MIX_WR: begin
				prev_q <= mix_new;
				i_q <= i_inc;
				if (!pass_q) j_q <= (j_ext == len_q) ? '0 : j_q + KAW'(1);
				k_q <= (k_q == CW'(1)) ? CW'(TW_LAST) : k_q - CW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			widx_q <= TW_NOT_SEEDED;
			kcnt_q <= '0;
			pass_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_GEN_WR && !stall) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req.op == OP_KEY && !key_full)
						kcnt_q <= kcnt_q + KCW'(1);
					pass_q <= 1'b0;
				end
				ST_SEED_WR: if (i_q == TW_LAST) widx_q <= 10'd0;
				ST_GEN_WR: if (!stall) widx_q <= widx_inc;
				ST_MIX_WR: if (k_q == CW'(1)) pass_q <= 1'b1;
				ST_FINAL: begin
					widx_q <= 10'd0;
					kcnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;

	assert property (@(posedge clk) disable iff (!arst_n) tw_we |-> tw_waddr < 10'(TW_N))
		else $error("state write out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		widx_q == TW_NOT_SEEDED || widx_q < 10'(TW_N))
		else $error("word index corrupt");
	assert property (@(posedge clk) disable iff (!arst_n) kcnt_q <= KCW'(KEY_DEPTH))
		else $error("key count beyond store depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN_WR && !stall) |=> out_valid_q)
		else $error("generated word not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN_RA) |-> !unseeded)
		else $error("twist started before seeding");
endmodule

// ===== rtl/mersenne_twister_generator.sv =====
// Generate: three state reads on one RAM port, then a write held while the previous output is not taken.
// Seed: a multiply step and a write step per state word; a generate before any
// seeding seeds with the default first. Key seeding: seed, then a read and a write
// step per mixing step over max(keys,624) + 623 steps. Key words are stored from idle.
// A generate result goes through the request queue, the read states and the write state.
// Reset clears control; state and key memories stay undefined until written.
module mersenne_twister_generator #(
	parameter int KEY_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [31:0] data,
	input logic last,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] value
);
	import mtg_pkg::*;

	req_t req;
	logic req_valid;
	logic req_ready;

	mtg_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .data(data), .last(last),
		.req_valid(req_valid), .req_ready(req_ready), .req(req)
	);

	mtg_back #(.KEY_DEPTH(KEY_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .out_valid(out_valid), .out_ready(out_ready), .value(value)
	);
endmodule

// ===== tb/tb_mersenne_twister_generator.sv =====
// Testbench for the Mersenne Twister generator: predicts each tempered output and checks it.
`timescale 1ns / 100ps

module tb_mersenne_twister_generator;
	import mtg_pkg::*;

	localparam int KEY_DEPTH = 1024;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_GENERATE;
	logic [31:0] data = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] value;

	logic [31:0] mt_words [TW_N];
	logic [31:0] key_words [KEY_DEPTH];
	int unsigned mt_pos = TW_NOT_SEEDED;
	int unsigned key_fill = 0;
	logic [31:0] expected_values [$];
	int errors = 0;
	int idle_cycles = 0;
	bit sender_pauses = 1'b1;
	bit receiver_pauses = 1'b1;
	bit hold_request = 1'b0;
	int hold_off = 0;

	mersenne_twister_generator #(.KEY_DEPTH(KEY_DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .data(data), .last(last), .out_valid(out_valid),
		.out_ready(out_ready), .value(value)
	);

	always #6 clk = ~clk;

	function automatic void seed_state(logic [31:0] s);
		logic [31:0] p;
		mt_words[0] = s;
		for (int i = 1; i < TW_N; i++) begin
			p = mt_words[i-1];
			mt_words[i] = MUL_SEED * (p ^ (p >> 30)) + 32'(i);
		end
		mt_pos = 0;
	endfunction

	function automatic void seed_from_key(int unsigned len);
		int unsigned i, j, k;
		logic [31:0] p;
		i = 1;
		j = 0;
		seed_state(SEED_KEY);
		k = (len > TW_N) ? len : TW_N;
		while (k > 0) begin
			p = mt_words[i-1];
			mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * MUL_MIX1)) + key_words[j] + 32'(j);
			i++;
			if (i >= TW_N) begin
				mt_words[0] = mt_words[TW_N-1];
				i = 1;
			end
			j++;
			if (j >= len) j = 0;
			k--;
		end
		for (k = TW_N - 1; k > 0; k--) begin
			p = mt_words[i-1];
			mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * MUL_MIX2)) - 32'(i);
			i++;
			if (i >= TW_N) begin
				mt_words[0] = mt_words[TW_N-1];
				i = 1;
			end
		end
		mt_words[0] = TW_UPPER;
		mt_pos = 0;
	endfunction

	function automatic logic [31:0] next_tempered();
		logic [31:0] y, w;
		int unsigned i;
		if (mt_pos >= TW_N) seed_state(SEED_DEFAULT);
		i = mt_pos;
		y = (mt_words[i] & TW_UPPER) | (mt_words[(i+1) % TW_N] & ~TW_UPPER);
		w = mt_words[(i + TW_M) % TW_N] ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
		mt_words[i] = w;
		mt_pos = (i + 1) % TW_N;
		w ^= w >> 11;
		w ^= (w << 7) & TEMPER_B;
		w ^= (w << 15) & TEMPER_C;
		w ^= w >> 18;
		return w;
	endfunction

	function automatic void predict(logic [1:0] c, logic [31:0] d, logic l);
		case (c)
			CMD_GENERATE: expected_values.push_back(next_tempered());
			CMD_SEED: seed_state(d);
			CMD_KEY: begin
				if (key_fill < KEY_DEPTH) begin
					key_words[key_fill] = d;
					key_fill++;
				end
				if (l) begin
					seed_from_key(key_fill);
					key_fill = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// Send one request; hold it until accepted.
	task automatic send(logic [1:0] c, logic [31:0] d, logic l);
		if (sender_pauses && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		cmd <= c;
		data <= d;
		last <= l;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict(c, d, l);
		@(negedge clk);
	endtask

	// Receiver stall pattern, with an optional long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request <= 1'b0;
			hold_off <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (receiver_pauses && $urandom_range(0, 4) == 0) begin
			hold_off <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected value, expected none, actual %h", $time, value);
				errors++;
			end else begin
				if (value !== expected_values[0]) begin
					$display("%0t: value expected %h, actual %h", $time,
						expected_values[0], value);
					errors++;
				end
				void'(expected_values.pop_front());
			end
		end
	end

	// Watchdog on cycles with no handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("mersenne_twister_generator: mismatch");
			$finish;
		end
	end

	task automatic rand_generates(int n);
		for (int k = 0; k < n; k++) send(CMD_GENERATE, $urandom(), 1'(($urandom())));
	endtask

	task automatic test_unseeded_generate();
		send(CMD_UNUSED, 32'hffffffff, 1'b1);
		send(CMD_GENERATE, 32'h0, 1'b0);
		send(CMD_GENERATE, 32'hffffffff, 1'b1);
	endtask

	task automatic test_seed_extremes();
		send(CMD_SEED, 32'h0, 1'b1);
		rand_generates(3);
		send(CMD_SEED, 32'hffffffff, 1'b0);
		rand_generates(3);
		send(CMD_SEED, 32'd5489, 1'b0);
		send(CMD_UNUSED, 32'h0, 1'b0);
		rand_generates(2);
	endtask

	task automatic test_key_seeding();
		send(CMD_KEY, 32'h123, 1'b0);
		send(CMD_SEED, 32'h0, 1'b0);     // pending key kept across a seed
		send(CMD_KEY, 32'h234, 1'b0);
		send(CMD_KEY, 32'h345, 1'b0);
		send(CMD_KEY, 32'h456, 1'b1);
		rand_generates(4);
		send(CMD_KEY, 32'hffffffff, 1'b1);
		rand_generates(2);
	endtask

	// Key of 17 words, opening with extreme values.
	task automatic test_long_keys();
		send(CMD_KEY, 32'hffffffff, 1'b0);
		send(CMD_KEY, 32'h0, 1'b0);
		for (int k = 0; k < 14; k++) send(CMD_KEY, $urandom(), 1'b0);
		send(CMD_KEY, $urandom(), 1'b1);
		rand_generates(3);
	endtask

	// Wrap the word index past the end of the state.
	task automatic test_index_wrap();
		rand_generates(TW_N + 2);
	endtask

	task automatic test_backpressure();
		hold_request <= 1'b1;
		rand_generates(20);
	endtask

	task automatic test_random_mix();
		int r;
		for (int k = 0; k < 30; k++) begin
			r = $urandom_range(0, 99);
			if (r < 85) send(CMD_GENERATE, $urandom(), 1'($urandom()));
			else if (r < 89) send(CMD_SEED, $urandom(), 1'($urandom()));
			else if (r < 97) send(CMD_KEY, $urandom(), $urandom_range(0, 3) == 0);
			else send(CMD_UNUSED, $urandom(), 1'($urandom()));
		end
	endtask

	task automatic test_no_idling();
		sender_pauses = 1'b0;
		receiver_pauses = 1'b0;
		rand_generates(24);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_unseeded_generate();
		test_seed_extremes();
		test_key_seeding();
		test_index_wrap();
		test_long_keys();
		test_backpressure();
		test_random_mix();
		test_no_idling();
		in_valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_values.size() == 0)
			$display("mersenne_twister_generator: match");
		else
			$display("mersenne_twister_generator: mismatch");
		$finish;
	end

endmodule
